### rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the colour fade sequencer: palette nodes,
// register indexes and the command/status bundles between its two halves.
// ----------------------------------------------------------------------------
package cfs_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP    = 4'd1;

	localparam logic [15:0] STEP_COUNT_RST = 16'd200;
	localparam logic [15:0] MIN_GAP_RST    = 16'd5;

	// quotient is always below 256, so eight restoring steps suffice
	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = 3;

	// palette nodes, 0xGGRRBB; unused tail holds red
	localparam logic [23:0] PALETTE [0:15] = '{
		24'h00FF00, 24'h40FF00, 24'hFFEE00, 24'hFF0000,
		24'h800000, 24'h000080, 24'h0000FF, 24'h000080,
		24'h4000FF, 24'h8000FF, 24'h008080, 24'h00FF00,
		24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00
	};

	// controller to datapath
	typedef struct packed {
		logic first;     // first item: latch time, restart fade
		logic latch;     // latch time of an acting item
		logic fade;      // compute colour, register products
		logic advance;   // move to next segment
		logic prep;      // form dividends
		logic div_step;  // one restoring division step
		logic load_out;  // load result into output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic started;
		logic elapsed_ok;
		logic fade_ok;
		logic out_busy;
	} status_t;

endpackage

### rtl/cfs_datapath.sv
// ----------------------------------------------------------------------------
// cfs_datapath
// Sequencer state, configuration registers, three fade lanes with a shared
// divisor shifter, and the output register.
// ----------------------------------------------------------------------------
module cfs_datapath #(
	parameter int SEGMENTS = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfs_pkg::cmd_t                     cmd,
	output cfs_pkg::status_t                  status,
	input  logic [31:0]                       now_ms,
	input  logic                              cfg_we,
	input  logic [cfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        green,
	output logic [7:0]                        red,
	output logic [7:0]                        blue
);

	logic [15:0] step_count_q;
	logic [15:0] delay_q;
	logic        started_q;
	logic [3:0]  segment_q;
	logic [16:0] step_pos_q;
	logic [31:0] last_time_q;
	logic        out_valid_q;

	logic [15:0] n;
	logic [31:0] elapsed;
	logic [3:0]  seg_next;
	logic [3:0]  seg_inc;
	logic [23:0] node_a;
	logic [23:0] node_b;
	logic [22:0] dvs_q;
	logic [7:0]  res [3];

	// effective divisor: zero counts as one
	assign n = (step_count_q == 16'd0) ? 16'd1 : step_count_q;

	assign elapsed = now_ms - last_time_q;
	assign seg_inc = segment_q + 4'd1;
	assign seg_next = ({1'b0, seg_inc} >= 5'(SEGMENTS)) ? 4'd0 : seg_inc;

	assign node_a = cfs_pkg::PALETTE[segment_q];
	assign node_b = cfs_pkg::PALETTE[seg_inc];

	always_comb begin
		status.started    = started_q;
		status.elapsed_ok = elapsed >= {16'd0, delay_q};
		status.fade_ok    = step_pos_q <= {1'b0, n};
		status.out_busy   = out_valid_q && !out_ready;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= cfs_pkg::STEP_COUNT_RST;
			delay_q      <= cfs_pkg::MIN_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cfs_pkg::REG_STEP_COUNT: step_count_q <= cfg_data;
				cfs_pkg::REG_MIN_GAP:    delay_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			segment_q   <= 4'd0;
			step_pos_q  <= 17'd0;
			last_time_q <= 32'd0;
		end else begin
			if (cmd.first) begin
				started_q  <= 1'b1;
				segment_q  <= 4'd0;
				step_pos_q <= 17'd0;
			end
			if (cmd.first || cmd.latch)
				last_time_q <= now_ms;
			if (cmd.fade)
				step_pos_q <= step_pos_q + 17'd1;
			if (cmd.advance) begin
				segment_q  <= seg_next;
				step_pos_q <= 17'd0;
			end
		end
	end

	// shared divisor, walked down one bit per step
	always_ff @(posedge clk) begin
		if (cmd.prep)
			dvs_q <= {n, 7'd0};
		else if (cmd.div_step)
			dvs_q <= dvs_q >> 1;
	end

	// one lane per colour channel: green, red, blue
	for (genvar c = 0; c < 3; c++) begin : g_lane
		localparam int SH = 8 * (2 - c);

		logic [7:0]         sb;
		logic [7:0]         eb;
		logic signed [8:0]  diff;
		logic signed [26:0] prod_s1;
		logic [7:0]         start_s1;
		logic signed [26:0] num;
		logic signed [26:0] mag;
		logic [23:0]        rem_q;
		logic [7:0]         quo_q;
		logic               neg_q;
		logic signed [10:0] sq;
		logic signed [10:0] v;

		assign sb   = node_a[SH +: 8];
		assign eb   = node_b[SH +: 8];
		assign diff = $signed({1'b0, eb}) - $signed({1'b0, sb});
		assign num  = prod_s1 + $signed({11'd0, n >> 1});
		assign mag  = num[26] ? -num : num;

		// product of node difference and step position
		always_ff @(posedge clk) begin
			if (cmd.fade) begin
				prod_s1  <= diff * $signed({1'b0, step_pos_q});
				start_s1 <= sb;
			end
		end

		// sign/magnitude restoring division, quotient MSB first
		always_ff @(posedge clk) begin
			if (cmd.prep) begin
				rem_q <= mag[23:0];
				neg_q <= num[26];
				quo_q <= 8'd0;
			end else if (cmd.div_step) begin
				if ({1'b0, rem_q} >= {2'b0, dvs_q}) begin
					rem_q <= rem_q - {1'b0, dvs_q};
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					quo_q <= {quo_q[6:0], 1'b0};
				end
			end
		end

		// truncated quotient back to signed, add start, clamp
		always_comb begin
			sq = $signed({3'd0, quo_q});
			v  = (neg_q ? -sq : sq) + $signed({3'd0, start_s1});
			if (v < 0)
				res[c] = 8'd0;
			else if (v > 11'sd255)
				res[c] = 8'd255;
			else
				res[c] = v[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			green <= res[0];
			red   <= res[1];
			blue  <= res[2];
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/cfs_ctrl.sv
// ----------------------------------------------------------------------------
// cfs_ctrl
// Controller: takes items, decides the action and sequences the division.
// ----------------------------------------------------------------------------
module cfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cfs_pkg::status_t status,
	output cfs_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                    state_q;
	state_t                    state_d;
	logic [cfs_pkg::CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!status.started) begin
						cmd.first = 1'b1;
					end else if (status.elapsed_ok) begin
						cmd.latch = 1'b1;
						if (status.fade_ok) begin
							cmd.fade = 1'b1;
							state_d  = ST_PREP;
						end else begin
							cmd.advance = 1'b1;
						end
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == cfs_pkg::CNT_W'(cfs_pkg::DIV_STEPS - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule

### rtl/color_fade_sequencer.sv
// A colour-producing item passes the product register, operand set-up, eight
// restoring division steps run side by side in the three lanes and the output
// load; a new item is taken only after the load, and a stalled result delays
// the load. Items that give no colour (first item, too early, segment change)
// are taken one per cycle.
// Reset: asynchronous; state cleared, step count 200 and minimum gap 5 ms.
// ----------------------------------------------------------------------------
// color_fade_sequencer
// Steps a colour through a loop of palette nodes with linear fades,
// paced by a millisecond timestamp.
// ----------------------------------------------------------------------------
module color_fade_sequencer #(
	parameter int SEGMENTS = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [31:0]                      now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       green,
	output logic [7:0]                       red,
	output logic [7:0]                       blue,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [cfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	cfs_pkg::cmd_t    cmd;
	cfs_pkg::status_t status;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	cfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cfs_datapath #(
		.SEGMENTS (SEGMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.now_ms    (now_ms),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.green     (green),
		.red       (red),
		.blue      (blue)
	);

endmodule

### rtl/cfs_checker.sv
// ----------------------------------------------------------------------------
// cfs_checker
// Port-level checks of the colour fade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module cfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [31:0]                      now_ms,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [7:0]                       green,
	input logic [7:0]                       red,
	input logic [7:0]                       blue,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [cfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [cfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// a stalled result holds its colour
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(green) && $stable(red)
			&& $stable(blue))
		else $error("result changed while stalled");

	// a new result only appears at the end of a busy spell
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2))
		else $error("result raised without a preceding computation");

	// input is not taken in the state that follows the first busy state of a computation
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 !in_ready |=> !in_ready)
		else $error("input taken in the middle of a computation");

	// configuration writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind color_fade_sequencer cfs_checker u_cfs_checker (.*);

### tb/color_fade_sequencer_test.sv
// ----------------------------------------------------------------------------
// color_fade_sequencer_test
// Drives millisecond timestamps into the colour fade sequencer and checks
// every colour against a cycle-free prediction of the fade: time pacing,
// segment walk, interpolation and clamping. Registers are rewritten between
// phases, both handshakes idle at random, and the output is held off once
// long enough to back the block up.
// ----------------------------------------------------------------------------
module color_fade_sequencer_test;

	localparam int NUM_SEGS      = 11;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_MAX    = 10;

	// index with no register behind it, written once to show it is ignored
	localparam logic [cfs_pkg::CFG_INDEX_W-1:0] REG_SPARE = 4'd9;

	// palette nodes 0xGGRRBB, tail padded with red
	localparam logic [23:0] NODES [0:15] = '{
		24'h00FF00, 24'h40FF00, 24'hFFEE00, 24'hFF0000,
		24'h800000, 24'h000080, 24'h0000FF, 24'h000080,
		24'h4000FF, 24'h8000FF, 24'h008080, 24'h00FF00,
		24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00
	};

	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} colour_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	logic [31:0]                     now_ms    = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [7:0]                      green;
	logic [7:0]                      red;
	logic [7:0]                      blue;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [cfs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	color_fade_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.green     (green),
		.red       (red),
		.blue      (blue),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timestamps waiting for the driver, colours waiting for the block
	logic [31:0] pending_times [$];
	colour_t     due_colours [$];

	int  n_pushed   = 0;
	int  n_taken    = 0;
	int  mismatches = 0;
	int  idle_pct   = 12;
	int  hold_req   = 0;
	int  cycle_count = 0;
	bit  in_acc  = 1'b0;
	bit  cfg_acc = 1'b0;

	// predicted block state and registers
	logic [15:0] fade_steps   = cfs_pkg::STEP_COUNT_RST;
	logic [15:0] fade_delay   = cfs_pkg::MIN_GAP_RST;
	bit          fade_started = 1'b0;
	logic [3:0]  fade_seg     = '0;
	logic [16:0] fade_pos     = '0;
	logic [31:0] fade_last    = '0;

	// stimulus-side view of time pacing, used only to shape items
	bit          pace_started = 1'b0;
	logic [31:0] pace_last    = '0;
	logic [15:0] pace_delay   = cfs_pkg::MIN_GAP_RST;

	// one channel of the linear fade, truncating division, clamped
	function automatic logic [7:0] blend(input logic [7:0] s, input logic [7:0] e,
			input logic [16:0] k, input logic [16:0] n);
		int v;
		v = ((int'(e) - int'(s)) * int'(k) + int'(n >> 1)) / int'(n) + int'(s);
		if (v < 0)
			v = 0;
		else if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// advance the predicted fade by one accepted timestamp
	task automatic step_fade(input logic [31:0] t);
		logic [16:0] n;
		logic [31:0] elapsed;
		logic [23:0] a;
		logic [23:0] b;
		colour_t     c;
		n = (fade_steps == 16'd0) ? 17'd1 : {1'b0, fade_steps};
		elapsed = t - fade_last;
		if (!fade_started) begin
			fade_started = 1'b1;
			fade_last = t;
			fade_seg = '0;
			fade_pos = '0;
		end else if (elapsed >= {16'd0, fade_delay}) begin
			fade_last = t;
			if (fade_pos <= n) begin
				a = NODES[fade_seg];
				b = NODES[fade_seg + 4'd1];
				c.green = blend(a[23:16], b[23:16], fade_pos, n);
				c.red   = blend(a[15:8], b[15:8], fade_pos, n);
				c.blue  = blend(a[7:0], b[7:0], fade_pos, n);
				due_colours.push_back(c);
				fade_pos = fade_pos + 17'd1;
			end else begin
				fade_seg = (int'(fade_seg) + 1 >= NUM_SEGS) ? 4'd0 : fade_seg + 4'd1;
				fade_pos = '0;
			end
		end
	endtask

	task automatic log_fault(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// queue a timestamp; returns whether it would make the block act
	function automatic bit offer(input logic [31:0] t);
		logic [31:0] gap;
		bit          acts;
		gap = t - pace_last;
		acts = !pace_started || (gap >= {16'd0, pace_delay});
		if (acts) begin
			pace_started = 1'b1;
			pace_last = t;
		end
		pending_times.push_back(t);
		n_pushed++;
		return acts;
	endfunction

	// driver: timestamps change on the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_acc) begin
			if (pending_times.size() > 0 &&
					!(idle_pct > 0 && $urandom_range(99) < idle_pct)) begin
				in_valid <= 1'b1;
				now_ms <= pending_times.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	int hold_seen = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
		end
	end

	// monitor: every transfer seen at the rising edge
	always @(posedge clk) begin
		in_acc <= in_valid && in_ready;
		cfg_acc <= cfg_valid && cfg_ready;
		if (arst_n) begin
			// results first, so a stray colour cannot match a fresh prediction
			if (out_valid && out_ready) begin
				if (due_colours.size() == 0) begin
					log_fault($sformatf("unexpected colour g=%02h r=%02h b=%02h",
						green, red, blue));
				end else begin
					colour_t exp_c;
					exp_c = due_colours.pop_front();
					if (exp_c.green !== green || exp_c.red !== red || exp_c.blue !== blue)
						log_fault($sformatf(
							"colour mismatch: expected g=%02h r=%02h b=%02h, got g=%02h r=%02h b=%02h",
							exp_c.green, exp_c.red, exp_c.blue, green, red, blue));
				end
			end
			if (in_valid && in_ready) begin
				step_fade(now_ms);
				n_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cfs_pkg::REG_STEP_COUNT: fade_steps = cfg_data;
					cfs_pkg::REG_MIN_GAP:    fade_delay = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("color_fade_sequencer_test: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [cfs_pkg::CFG_INDEX_W-1:0] idx,
			input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_acc);
		cfg_valid <= 1'b0;
	endtask

	// everything offered has been taken and every colour has come back
	task automatic wait_drained;
		while (!(pending_times.size() == 0 && n_taken == n_pushed &&
				due_colours.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fade(input logic [15:0] steps, input logic [15:0] delay_val);
		wait_drained();
		write_reg(cfs_pkg::REG_STEP_COUNT, steps);
		write_reg(cfs_pkg::REG_MIN_GAP, delay_val);
		pace_delay = delay_val;
	endtask

	// mostly paced ticks, with early ticks, big jumps and raw noise mixed in
	task automatic run_fades(input int acts_wanted);
		int          acts;
		int          pick;
		logic [31:0] gap;
		logic [31:0] t;
		acts = 0;
		while (acts < acts_wanted) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				gap = {16'd0, pace_delay} + $urandom_range(3);
				t = pace_last + gap;
			end else if (pick < 80) begin
				gap = $urandom;
				if (gap < {16'd0, pace_delay})
					gap = {16'd0, pace_delay};
				t = pace_last + gap;
			end else if (pick < 92) begin
				gap = (pace_delay == 16'd0) ? 32'd0 : $urandom_range(pace_delay - 1);
				t = pace_last + gap;
			end else begin
				t = $urandom;
			end
			if (offer(t))
				acts++;
		end
	endtask

	initial begin
		bit dummy;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset registers: first tick only latches, then early/exact/wrapped ticks
		dummy = offer(32'hFFFF_FFFA);
		dummy = offer(32'hFFFF_FFFE);
		dummy = offer(32'hFFFF_FFFF);
		dummy = offer(32'h0000_0004);
		dummy = offer(32'h0000_0008);
		dummy = offer(32'h0000_0009);

		// zero step count acts as one; zero delay lets every tick act
		set_fade(16'd0, 16'd0);
		dummy = offer(32'hFFFF_FFFF);
		dummy = offer(32'h0000_0000);
		dummy = offer(32'h8000_0000);
		dummy = offer(32'h7FFF_FFFF);
		dummy = offer(32'h5555_5555);
		dummy = offer(32'hAAAA_AAAA);
		dummy = offer(32'hAAAA_AAAA);
		dummy = offer(32'h0000_0001);

		// widest registers; spare index must change nothing
		set_fade(16'hFFFF, 16'hFFFF);
		write_reg(REG_SPARE, 16'hFFFF);
		dummy = offer(pace_last + 32'd65534);
		dummy = offer(pace_last + 32'd65535);
		dummy = offer(pace_last + 32'hFFFF_FFFF);

		set_fade(16'd1, 16'd1);
		run_fades(200);

		// long stretch without idling on either side
		set_fade(16'd2, 16'd0);
		idle_pct = 0;
		run_fades(250);
		wait_drained();
		idle_pct = 12;

		// output held off while ticks keep coming
		set_fade(16'd40, 16'd3);
		hold_req++;
		run_fades(120);

		// step count lowered mid-fade; sender pauses halfway
		set_fade(16'd3, 16'd10);
		run_fades(100);
		wait_drained();
		run_fades(100);

		set_fade(16'hFFFF, 16'hFFFF);
		run_fades(60);

		set_fade(16'd0, 16'd2);
		run_fades(150);

		repeat (4) begin
			set_fade(16'($urandom_range(1, 8)), 16'($urandom_range(0, 50)));
			run_fades(150);
		end

		wait_drained();
		if (mismatches == 0 && due_colours.size() == 0) begin
			$display("color_fade_sequencer_test: PASS");
		end else begin
			$display("color_fade_sequencer_test: FAIL");
		end
		$finish;
	end

endmodule
